@@ design/json_token_lexer_macros.svh @@
// Assertion macros shared by the json_token_lexer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("json_token_lexer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define JTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("json_token_lexer: next-cycle check failed");

`endif

@@ design/jtl_pkg.sv @@
// Package for the JSON token lexer: offset width, token kinds, keyword spellings
// and the result slot type. Used by the output channel interface and the top level.
`default_nettype none

package jtl_pkg;

  localparam int OFFSET_BITS = 32;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [3:0]             kind_t;

  localparam kind_t KIND_NUMBER    = 4'd0;
  localparam kind_t KIND_NULL      = 4'd1;
  localparam kind_t KIND_FALSE     = 4'd2;
  localparam kind_t KIND_TRUE      = 4'd3;
  localparam kind_t KIND_IDENT     = 4'd4;
  localparam kind_t KIND_STRING    = 4'd5;
  localparam kind_t KIND_COMMA     = 4'd6;
  localparam kind_t KIND_COLON     = 4'd7;
  localparam kind_t KIND_LBRACE    = 4'd8;
  localparam kind_t KIND_RBRACE    = 4'd9;
  localparam kind_t KIND_LBRACKET  = 4'd10;
  localparam kind_t KIND_RBRACKET  = 4'd11;
  localparam kind_t KIND_EOF       = 4'd12;
  localparam kind_t KIND_BAD_BYTE  = 4'd13;
  localparam kind_t KIND_STR_NL    = 4'd14;
  localparam kind_t KIND_STR_EOF   = 4'd15;

  localparam logic [7:0] KW_NULL  [4] = '{"n", "u", "l", "l"};
  localparam logic [7:0] KW_FALSE [5] = '{"f", "a", "l", "s", "e"};
  localparam logic [7:0] KW_TRUE  [4] = '{"t", "r", "u", "e"};

  // Candidate bits: bit 0 null, bit 1 false, bit 2 true.
  localparam logic [2:0] CAND_ALL = 3'b111;
  localparam logic [2:0] WLEN_MAX = 3'd6;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
  } tok_t;

  // Reports an offset as its low 32 bits, zero-extended when narrower.
  function automatic logic [31:0] low32(offset_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

@@ design/jtl_in_if.sv @@
// Input channel of the JSON token lexer: one text byte per beat.
`default_nettype none

interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ design/jtl_out_if.sv @@
// Output channel of the JSON token lexer: one token per beat.
// Depends on jtl_pkg for the kind type.
`default_nettype none

interface jtl_out_if;
  logic           valid;
  logic           ready;
  jtl_pkg::kind_t token_kind;
  logic [31:0]    token_start;
  logic [31:0]    token_length;
  logic           run_end;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_end, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input run_end, output ready);
endinterface

`default_nettype wire

@@ design/json_token_lexer.sv @@
// Byte-serial JSON token lexer: takes one text byte per beat and gives tokens
// as kind, start offset and length. A byte is lexed in the cycle it is taken,
// and its tokens (up to three) land in a four-slot result register that drains
// one token per cycle while the receiver is ready. A byte that makes no token
// is taken every cycle, also while tokens wait; a byte that makes tokens is
// taken once at most one earlier token is left and leaves in that cycle. run_end
// marks the last token of each byte.
// Depends on jtl_pkg, jtl_in_if, jtl_out_if and json_token_lexer_macros.svh.
`default_nettype none

module json_token_lexer (
  input  wire logic clk,
  input  wire logic rst,
  jtl_in_if.sink    text,
  jtl_out_if.source tokens
);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_WORD   = 4'b0100,
    MODE_STRING = 4'b1000
  } lex_mode_t;

  // Lexer state.
  jtl_pkg::offset_t byte_offset, byte_offset_next;
  jtl_pkg::offset_t open_start, open_start_next;
  lex_mode_t        lex_mode, lex_mode_next;
  logic             escape_pending, escape_pending_next;
  logic [2:0]       keyword_candidates, keyword_candidates_next;
  logic [2:0]       word_length, word_length_next;

  // Result slots: old run closed, single token, run closed by end of text, eof.
  jtl_pkg::tok_t slots [4];
  jtl_pkg::tok_t slot_new [4];
  logic [3:0]    pend;
  logic [3:0]    new_mask;
  logic [1:0]    sel;
  logic          in_fire, out_fire;

  function automatic jtl_pkg::kind_t run_kind(lex_mode_t m, logic [2:0] cand,
                                              logic [2:0] wlen);
    jtl_pkg::kind_t k;
    k = jtl_pkg::KIND_NUMBER;
    if (m == MODE_STRING) begin
      k = jtl_pkg::KIND_STR_EOF;
    end else if (m == MODE_WORD) begin
      if (cand[0] && wlen == 3'd4) k = jtl_pkg::KIND_NULL;
      else if (cand[1] && wlen == 3'd5) k = jtl_pkg::KIND_FALSE;
      else if (cand[2] && wlen == 3'd4) k = jtl_pkg::KIND_TRUE;
      else k = jtl_pkg::KIND_IDENT;
    end
    return k;
  endfunction

  // Narrows the keyword candidates by one more letter at position i.
  function automatic logic [2:0] feed_cand(logic [2:0] cand, logic [2:0] i,
                                           logic [7:0] b);
    logic [2:0] c;
    c = cand;
    if (!(i < 3'd4 && b == jtl_pkg::KW_NULL[i[1:0]])) c[0] = 1'b0;
    if (!(i < 3'd5 && b == jtl_pkg::KW_FALSE[i])) c[1] = 1'b0;
    if (!(i < 3'd4 && b == jtl_pkg::KW_TRUE[i[1:0]])) c[2] = 1'b0;
    return c;
  endfunction

  function automatic logic [2:0] feed_len(logic [2:0] i);
    return (i < jtl_pkg::WLEN_MAX) ? i + 3'd1 : jtl_pkg::WLEN_MAX;
  endfunction

  logic [7:0]       b;
  logic             is_zero, is_ws, is_digit, is_alpha, is_num, num_start;
  logic             is_quote;
  jtl_pkg::offset_t pos1;
  lex_mode_t        mode_mid;
  jtl_pkg::offset_t open_mid;
  logic             esc_mid;
  logic [2:0]       cand_mid, wlen_mid;
  logic             relex;
  jtl_pkg::kind_t   punct_kind;

  always_comb begin
    b         = text.data_byte;
    is_zero   = (b == 8'h00);
    is_ws     = b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    is_digit  = b inside {["0":"9"]};
    is_alpha  = b inside {["a":"z"], ["A":"Z"]};
    is_num    = is_digit || (b inside {["a":"f"], ["A":"F"], ".", "+", "-"});
    num_start = is_digit || b == "+" || b == "-";
    is_quote  = (b == "\"");
    case (b)
      ",":     punct_kind = jtl_pkg::KIND_COMMA;
      ":":     punct_kind = jtl_pkg::KIND_COLON;
      "{":     punct_kind = jtl_pkg::KIND_LBRACE;
      "}":     punct_kind = jtl_pkg::KIND_RBRACE;
      "[":     punct_kind = jtl_pkg::KIND_LBRACKET;
      "]":     punct_kind = jtl_pkg::KIND_RBRACKET;
      default: punct_kind = jtl_pkg::KIND_BAD_BYTE;
    endcase
  end

  always_comb begin
    pos1     = byte_offset + jtl_pkg::offset_t'(1);
    new_mask = '0;
    for (int k = 0; k < 4; k++) slot_new[k] = '0;
    mode_mid = lex_mode;
    open_mid = open_start;
    esc_mid  = escape_pending;
    cand_mid = keyword_candidates;
    wlen_mid = word_length;
    relex    = 1'b0;

    // The run that was open before this byte, closed at this byte's offset.
    slot_new[0].kind  = run_kind(lex_mode, keyword_candidates, word_length);
    slot_new[0].start = jtl_pkg::low32(open_start);
    slot_new[0].len   = jtl_pkg::low32(byte_offset - open_start);

    if (is_zero) begin
      new_mask[0] = (lex_mode != MODE_IDLE);
    end else begin
      case (lex_mode)
        MODE_NUMBER: begin
          if (!is_num) begin
            new_mask[0] = 1'b1;
            relex       = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_alpha) begin
            cand_mid = feed_cand(keyword_candidates, word_length, b);
            wlen_mid = feed_len(word_length);
          end else begin
            new_mask[0] = 1'b1;
            relex       = 1'b1;
          end
        end
        MODE_STRING: begin
          slot_new[1].start = jtl_pkg::low32(open_start);
          slot_new[1].len   = jtl_pkg::low32(byte_offset - open_start);
          if (b == 8'h0A) begin
            new_mask[1]      = 1'b1;
            slot_new[1].kind = jtl_pkg::KIND_STR_NL;
            mode_mid         = MODE_IDLE;
            esc_mid          = 1'b0;
          end else if (b == "\\") begin
            esc_mid = !escape_pending;
          end else if (is_quote && !escape_pending) begin
            new_mask[1]      = 1'b1;
            slot_new[1].kind = jtl_pkg::KIND_STRING;
            mode_mid         = MODE_IDLE;
          end else begin
            esc_mid = 1'b0;
          end
        end
        default: relex = 1'b1;
      endcase

      if (relex) begin
        mode_mid = MODE_IDLE;
        esc_mid  = 1'b0;
        if (num_start) begin
          mode_mid = MODE_NUMBER;
          open_mid = byte_offset;
        end else if (is_alpha) begin
          mode_mid = MODE_WORD;
          open_mid = byte_offset;
          cand_mid = feed_cand(jtl_pkg::CAND_ALL, 3'd0, b);
          wlen_mid = 3'd1;
        end else if (is_quote) begin
          mode_mid = MODE_STRING;
          open_mid = pos1;
        end else if (!is_ws) begin
          new_mask[1]       = 1'b1;
          slot_new[1].kind  = punct_kind;
          slot_new[1].start = jtl_pkg::low32(byte_offset);
          slot_new[1].len   = 32'd1;
        end
      end
    end

    // A final byte closes whatever run this byte leaves open, then ends the text.
    new_mask[2]       = !is_zero && text.final_byte && (mode_mid != MODE_IDLE);
    slot_new[2].kind  = run_kind(mode_mid, cand_mid, wlen_mid);
    slot_new[2].start = jtl_pkg::low32(open_mid);
    slot_new[2].len   = jtl_pkg::low32(pos1 - open_mid);

    new_mask[3]       = is_zero || text.final_byte;
    slot_new[3].kind  = jtl_pkg::KIND_EOF;
    slot_new[3].start = jtl_pkg::low32(is_zero ? byte_offset : pos1);
    slot_new[3].len   = 32'd0;

    if (new_mask[3]) begin
      byte_offset_next        = '0;
      open_start_next         = '0;
      lex_mode_next           = MODE_IDLE;
      escape_pending_next     = 1'b0;
      keyword_candidates_next = jtl_pkg::CAND_ALL;
      word_length_next        = '0;
    end else begin
      byte_offset_next        = pos1;
      open_start_next         = open_mid;
      lex_mode_next           = mode_mid;
      escape_pending_next     = esc_mid;
      keyword_candidates_next = cand_mid;
      word_length_next        = wlen_mid;
    end
  end

  // Oldest pending slot goes out first.
  always_comb begin
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (pend[k]) sel = 2'(k);
    end
  end

  assign tokens.valid        = |pend;
  assign tokens.token_kind   = slots[sel].kind;
  assign tokens.token_start  = slots[sel].start;
  assign tokens.token_length = slots[sel].len;
  assign tokens.run_end      = ($countones(pend) == 1);

  assign out_fire   = tokens.valid && tokens.ready;
  // A byte that makes no token never touches the slots, so it may pass a stall.
  assign text.ready = (pend == '0) || (new_mask == '0) ||
                      ($onehot(pend) && tokens.ready);
  assign in_fire    = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset        <= '0;
      open_start         <= '0;
      lex_mode           <= MODE_IDLE;
      escape_pending     <= 1'b0;
      keyword_candidates <= jtl_pkg::CAND_ALL;
      word_length        <= '0;
      pend               <= '0;
    end else begin
      if (in_fire) begin
        byte_offset        <= byte_offset_next;
        open_start         <= open_start_next;
        lex_mode           <= lex_mode_next;
        escape_pending     <= escape_pending_next;
        keyword_candidates <= keyword_candidates_next;
        word_length        <= word_length_next;
      end
      if (in_fire && new_mask != '0) begin
        pend <= new_mask;
      end else if (out_fire) begin
        pend[sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && new_mask != '0) begin
      for (int k = 0; k < 4; k++) slots[k] <= slot_new[k];
    end
  end

`include "json_token_lexer_macros.svh"

  // A byte never makes all four kinds of slot at once.
  `JTL_ASSERT_NOW(a_pend_max, 1'b1, $countones(pend) <= 3)
  // The escape flag only lives inside a string.
  `JTL_ASSERT_NOW(a_esc_in_string, escape_pending, lex_mode == MODE_STRING)
  // A zero byte ends the text and restarts offsets at zero.
  `JTL_ASSERT_NEXT(a_zero_restarts, text.valid && text.ready && text.data_byte == 8'h00,
                   byte_offset == '0 && lex_mode == MODE_IDLE)
  // Tokens of an accepted byte replace the pending set whole.
  `JTL_ASSERT_NEXT(a_load_tokens, in_fire && new_mask != '0, pend == $past(new_mask))

endmodule

`default_nettype wire
